>>> rtl/fds_pkg.sv
package fds_pkg;

    localparam int KIND_W        = 2;
    localparam int AMOUNT_W      = 32;
    localparam int SLOT_W        = 5;
    localparam int FRAME_INDEX_W = 5;
    localparam int FRAME_TOTAL_W = 6;
    localparam int TIF_W         = 32;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_TICK      = 2'd0;
    localparam kind_t KIND_APPEND    = 2'd1;
    localparam kind_t KIND_SET_INDEX = 2'd2;
    localparam kind_t KIND_SET_DONE  = 2'd3;

    // configuration register indexes
    localparam logic CFG_LOOP_MODE  = 1'b0;
    localparam logic CFG_PAUSE_FLAG = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } fds_mod_stat_t;

endpackage

>>> rtl/fds_in_if.sv
interface fds_in_if import fds_pkg::*; ();

    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [AMOUNT_W-1:0] amount;
    logic [SLOT_W-1:0]   frame_slot;
    logic                done_value;

    modport source (
        output valid,
        output kind,
        output amount,
        output frame_slot,
        output done_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  amount,
        input  frame_slot,
        input  done_value,
        output ready
    );

endinterface

>>> rtl/fds_out_if.sv
interface fds_out_if import fds_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic                     done_res;
    logic [FRAME_TOTAL_W-1:0] frame_total;
    logic [TIF_W-1:0]         time_in_frame;

    modport source (
        output valid,
        output frame_index,
        output done_res,
        output frame_total,
        output time_in_frame,
        input  ready
    );

    modport sink (
        input  valid,
        input  frame_index,
        input  done_res,
        input  frame_total,
        input  time_in_frame,
        output ready
    );

endinterface

>>> rtl/fds_ram.sv
module fds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/fds_mod.sv
module fds_mod import fds_pkg::*; #(
    parameter int DV_W = 33,
    parameter int DS_W = 37
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DV_W-1:0] dividend,
    input  logic [DS_W-1:0] divisor,
    output fds_mod_stat_t   stat,
    output logic [DS_W-1:0] rem
);

    localparam int CNT_W = $clog2(DV_W + 1);

    logic [DV_W-1:0]  q_reg,   q_next;
    logic [DS_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DS_W:0]    trial;
    logic [DS_W:0]    trial_sub;

    // restoring remainder, one dividend bit per cycle
    always_comb
    begin
        trial     = {rem_reg, q_reg[DV_W-1]};
        trial_sub = trial - {1'b0, divisor};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DV_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor}) ? trial_sub[DS_W-1:0] : trial[DS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

>>> rtl/frame_duration_sequencer.sv
// one item in flight; append, set index and set done give their result through S_FIN and the output register
// tick: the beat, then the bit-serial remainder of elapsed time plus amount against the total,
// then the walk through the duration table, one frame per step (1 to MAX_FRAMES+1 steps),
// then S_FIN loads the output register once it is empty or being read;
// the next item is taken while the previous result still waits
// reset clears all control state; table entries are undefined until appended, no clearing pass
module frame_duration_sequencer import fds_pkg::*; #(
    parameter int MAX_FRAMES = 32,
    parameter int TIME_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic          cfg_data,
    fds_in_if.sink        item,
    fds_out_if.source     result
);

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int TB    = TIME_BITS;
    localparam int TOT_W = TIME_BITS + IDX_W;
    localparam int DV_W  = TIME_BITS + 1;
    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       state_reg,   state_next;
    logic             loop_reg;
    logic             pause_reg;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [TOT_W-1:0] total_reg,   total_next;
    logic [TB-1:0]    elapsed_reg, elapsed_next;
    logic [IDX_W-1:0] idx_reg,     idx_next;
    logic             done_reg,    done_next;
    logic [TOT_W-1:0] t_reg,       t_next;
    logic [CNT_W-1:0] n_reg,       n_next;

    logic                     out_valid_reg, out_valid_next;
    logic [FRAME_INDEX_W-1:0] out_index_reg;
    logic                     out_done_reg;
    logic [FRAME_TOTAL_W-1:0] out_total_reg;
    logic [TIF_W-1:0]         out_time_reg;
    logic                     out_load;

    logic [TB-1:0]    amt;
    logic [IDX_W-1:0] last_idx;
    logic [CMP_W-1:0] slot_w;
    logic [CMP_W-1:0] last_w;
    logic [DV_W-1:0]  mod_dividend;
    logic             mod_start;
    fds_mod_stat_t    mod_stat;
    logic [TOT_W-1:0] mod_rem;
    logic             ram_we;
    logic [TB-1:0]    ram_rdata;
    logic [TOT_W-1:0] dur;
    logic             fits;
    logic [TOT_W-1:0] t_sub;
    logic [CNT_W-1:0] idx_inc;
    logic             wrap;
    logic             stop;
    logic [TOT_W-1:0] sat_src;
    logic [TB-1:0]    sat_val;

    fds_mod #(
        .DV_W (DV_W),
        .DS_W (TOT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (total_reg),
        .stat     (mod_stat),
        .rem      (mod_rem)
    );

    // read address follows the next index, so rdata always holds the current frame
    fds_ram #(
        .WIDTH (TB),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (amt),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    assign amt          = TB'(item.amount);
    assign last_idx     = (count_reg == '0) ? '0 : IDX_W'(count_reg - 1'b1);
    assign slot_w       = CMP_W'(item.frame_slot);
    assign last_w       = CMP_W'(last_idx);
    assign mod_dividend = {1'b0, elapsed_reg} + {1'b0, amt};

    assign dur     = TOT_W'(ram_rdata);
    assign fits    = t_reg >= dur;
    assign t_sub   = t_reg - dur;
    assign idx_inc = CNT_W'(idx_reg) + 1'b1;
    assign wrap    = idx_inc >= count_reg;
    assign sat_src = fits ? t_sub : t_reg;
    assign sat_val = (|sat_src[TOT_W-1:TB]) ? '1 : sat_src[TB-1:0];

    assign item.ready = (state_reg == S_IDLE);
    assign out_load   = (state_reg == S_FIN) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        elapsed_next = elapsed_reg;
        idx_next     = idx_reg;
        done_next    = done_reg;
        t_next       = t_reg;
        n_next       = n_reg;
        mod_start    = 1'b0;
        ram_we       = 1'b0;
        stop         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = S_FIN;
                    case (item.kind)
                        KIND_TICK:
                        begin
                            if (!pause_reg && !done_reg && count_reg != '0 && total_reg != '0)
                            begin
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                                if (CNT_W'(idx_reg) >= count_reg)
                                begin
                                    idx_next = last_idx;
                                end
                            end
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_FRAMES))
                            begin
                                ram_we     = 1'b1;
                                total_next = total_reg + TOT_W'(amt);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_SET_INDEX:
                        begin
                            idx_next = (slot_w < last_w) ? IDX_W'(slot_w) : last_idx;
                        end
                        KIND_SET_DONE:
                        begin
                            idx_next  = last_idx;
                            done_next = item.done_value;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_stat.done)
                begin
                    t_next     = mod_rem;
                    n_next     = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (!fits)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    t_next = t_sub;
                    n_next = n_reg + 1'b1;
                    if (wrap)
                    begin
                        if (loop_reg)
                        begin
                            idx_next = '0;
                        end
                        else
                        begin
                            idx_next  = last_idx;
                            done_next = 1'b1;
                            stop      = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = IDX_W'(idx_inc);
                    end
                    // walk is bounded at MAX_FRAMES+1 steps
                    if (n_reg == CNT_W'(MAX_FRAMES))
                    begin
                        stop = 1'b1;
                    end
                end
                if (stop)
                begin
                    elapsed_next = sat_val;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loop_reg      <= 1'b0;
            pause_reg     <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
            elapsed_reg   <= '0;
            idx_reg       <= '0;
            done_reg      <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            elapsed_reg   <= elapsed_next;
            idx_reg       <= idx_next;
            done_reg      <= done_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOOP_MODE:  loop_reg  <= cfg_data;
                    CFG_PAUSE_FLAG: pause_reg <= cfg_data;
                    default:        loop_reg  <= loop_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        if (out_load)
        begin
            out_index_reg <= FRAME_INDEX_W'(idx_reg);
            out_done_reg  <= done_reg;
            out_total_reg <= FRAME_TOTAL_W'(count_reg);
            out_time_reg  <= TIF_W'(elapsed_reg);
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.frame_index   = out_index_reg;
    assign result.done_res      = out_done_reg;
    assign result.frame_total   = out_total_reg;
    assign result.time_in_frame = out_time_reg;

`ifndef SYNTHESIS
    a_walk_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> (count_reg != '0 && total_reg != '0))
        else $error("walk with empty table");

    a_walk_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> CNT_W'(idx_reg) < count_reg)
        else $error("walk index beyond loaded frames");

    a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.done |-> state_reg == S_MOD)
        else $error("remainder finished outside tick");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count overflow");

    a_table_stable_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD || state_reg == S_WALK) |=> $stable(total_reg))
        else $error("total changed during tick");
`endif

endmodule

>>> bench/frame_duration_sequencer_tb.sv
module frame_duration_sequencer_tb import fds_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   NUM_FRAMES    = 32;
    localparam int   TIME_W        = 32;
    localparam int   PHASE_ITEMS   = 325;
    localparam int   NUM_PHASES    = 6;
    localparam int   SETTLE_CYCLES = 80;
    localparam int   CYCLE_LIMIT   = 1500000;

    typedef struct packed {
        logic [FRAME_INDEX_W-1:0] frame_index;
        logic                     done_res;
        logic [FRAME_TOTAL_W-1:0] frame_total;
        logic [TIF_W-1:0]         time_in_frame;
    } frame_status_t;

    class frame_seq_scoreboard;
        bit [AMOUNT_W-1:0] durations [NUM_FRAMES];
        int unsigned       frames_loaded;
        bit [36:0]         total_us;
        bit [TIME_W-1:0]   time_in_cur;
        int unsigned       cur_frame;
        bit                finished;
        bit                looping;
        bit                paused;
        frame_status_t     expected_status [$];
        int unsigned       errors;

        function void write_register(logic idx, logic val);
            if (idx == CFG_LOOP_MODE)
                looping = val;
            else
                paused = val;
        endfunction

        function int unsigned last_frame();
            return (frames_loaded == 0) ? 0 : frames_loaded - 1;
        endfunction

        function void run_tick(bit [AMOUNT_W-1:0] dt);
            bit [63:0] t;
            bit [63:0] d;
            if (paused || finished || frames_loaded == 0 || total_us == 0)
                return;
            t = (64'(time_in_cur) + 64'(dt)) % 64'(total_us);
            if (cur_frame >= frames_loaded)
                cur_frame = last_frame();
            // walk past every frame that fits, at most one full lap plus one
            for (int n = 0; n <= NUM_FRAMES; n++)
            begin
                d = 64'(durations[cur_frame]);
                if (t < d)
                    break;
                t -= d;
                cur_frame++;
                if (cur_frame >= frames_loaded)
                begin
                    if (looping)
                        cur_frame = 0;
                    else
                    begin
                        cur_frame = last_frame();
                        finished  = 1'b1;
                        break;
                    end
                end
            end
            time_in_cur = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        endfunction

        function void note_item(kind_t kind, bit [AMOUNT_W-1:0] amount,
                                bit [SLOT_W-1:0] slot, bit dv);
            frame_status_t exp_st;
            int unsigned   last;
            last = last_frame();
            case (kind)
                KIND_TICK:
                    run_tick(amount);
                KIND_APPEND:
                    if (frames_loaded < NUM_FRAMES)
                    begin
                        durations[frames_loaded] = amount;
                        total_us += 37'(amount);
                        frames_loaded++;
                    end
                KIND_SET_INDEX:
                    cur_frame = (slot < last) ? slot : last;
                default:
                begin
                    cur_frame = last;
                    finished  = dv;
                end
            endcase
            exp_st.frame_index   = cur_frame[FRAME_INDEX_W-1:0];
            exp_st.done_res      = finished;
            exp_st.frame_total   = frames_loaded[FRAME_TOTAL_W-1:0];
            exp_st.time_in_frame = time_in_cur;
            expected_status = {expected_status, exp_st};
        endfunction

        function void check_result(frame_status_t got);
            frame_status_t exp_st;
            if (expected_status.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            exp_st = expected_status.pop_front();
            if (got.frame_index !== exp_st.frame_index)
            begin
                $display("%0t: frame_index expected %0d actual %0d",
                         $time, exp_st.frame_index, got.frame_index);
                errors++;
            end
            if (got.done_res !== exp_st.done_res)
            begin
                $display("%0t: done_res expected %0d actual %0d",
                         $time, exp_st.done_res, got.done_res);
                errors++;
            end
            if (got.frame_total !== exp_st.frame_total)
            begin
                $display("%0t: frame_total expected %0d actual %0d",
                         $time, exp_st.frame_total, got.frame_total);
                errors++;
            end
            if (got.time_in_frame !== exp_st.time_in_frame)
            begin
                $display("%0t: time_in_frame expected %0d actual %0d",
                         $time, exp_st.time_in_frame, got.time_in_frame);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_data;
    bit   gaps_on;
    int unsigned cycle_count;

    fds_in_if  item_ch ();
    fds_out_if result_ch ();

    frame_seq_scoreboard sb;

    frame_duration_sequencer #(
        .MAX_FRAMES (NUM_FRAMES),
        .TIME_BITS  (TIME_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_item(kind_t kind, logic [AMOUNT_W-1:0] amount,
                             logic [SLOT_W-1:0] slot, logic dv);
        while (gaps_on && $urandom_range(99) < 21)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= kind;
        item_ch.amount     <= amount;
        item_ch.frame_slot <= slot;
        item_ch.done_value <= dv;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_item(kind, amount, slot, dv);
    endtask

    task automatic write_cfg(logic idx, logic val);
        item_ch.valid <= 1'b0;
        cfg_we        <= 1'b1;
        cfg_index     <= idx;
        cfg_data      <= val;
        @(posedge clk);
        cfg_we        <= 1'b0;
        @(posedge clk);
        sb.write_register(idx, val);
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge clk);
        // a tick may still be walking the table after its beat
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_item();
        logic [AMOUNT_W-1:0] amount;
        logic [SLOT_W-1:0]   slot;
        logic                dv;
        bit [37:0]           cap;
        int unsigned         r;
        kind_t               kind;
        amount = $urandom();
        slot   = $urandom_range(31);
        dv     = ($urandom_range(99) < 30);
        r      = $urandom_range(99);
        if (r < 3)
        begin
            kind = KIND_APPEND;
            r    = $urandom_range(99);
            // long frames only late, so most of the run walks a short table
            if (sb.frames_loaded >= 24 && r < 30)
                amount = $urandom();
            else if (r < 15)
                amount = '0;
            else if (r < 75)
                amount = $urandom_range(64, 1);
            else
                amount = $urandom_range(5000, 65);
        end
        else if (r < 63)
        begin
            kind = KIND_TICK;
            cap  = 38'(sb.total_us) * 2 + 8;
            if (cap > 38'hFFFF_FFFF)
                cap = 38'hFFFF_FFFF;
            r = $urandom_range(99);
            if (r < 20)
                amount = $urandom();
            else if (r < 35)
                amount = $urandom_range(3);
            else
                amount = $urandom_range(cap[31:0]);
        end
        else if (r < 83)
        begin
            kind = KIND_SET_INDEX;
            if ($urandom_range(99) < 30)
                slot = 5'd31;
        end
        else
            kind = KIND_SET_DONE;
        send_item(kind, amount, slot, dv);
    endtask

    // result side: random back-pressure, check every accepted beat
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result({result_ch.frame_index, result_ch.done_res,
                                 result_ch.frame_total, result_ch.time_in_frame});
            result_ch.ready <= !(gaps_on && $urandom_range(99) < 21);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        bit loop_sel  [NUM_PHASES];
        bit pause_sel [NUM_PHASES];

        loop_sel  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        pause_sel = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        sb = new();
        gaps_on = 1'b1;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= 1'b0;
        cfg_data           <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.kind       <= KIND_TICK;
        item_ch.amount     <= '0;
        item_ch.frame_slot <= '0;
        item_ch.done_value <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(CFG_LOOP_MODE, 1'b0);
        write_cfg(CFG_PAUSE_FLAG, 1'b0);

        // empty table: ticks do nothing, index and done land on frame 0
        send_item(KIND_TICK, 32'hFFFF_FFFF, 5'd0, 1'b0);
        send_item(KIND_SET_INDEX, 32'd0, 5'd31, 1'b0);
        send_item(KIND_SET_DONE, 32'd0, 5'd0, 1'b1);
        send_item(KIND_SET_DONE, 32'd0, 5'd31, 1'b0);
        // zero total
        send_item(KIND_APPEND, 32'd0, 5'd0, 1'b0);
        send_item(KIND_TICK, 32'd5, 5'd0, 1'b0);
        // short table with zero-duration frames to skip
        send_item(KIND_APPEND, 32'd3, 5'd0, 1'b0);
        send_item(KIND_APPEND, 32'd0, 5'd0, 1'b0);
        send_item(KIND_APPEND, 32'd4, 5'd0, 1'b0);
        send_item(KIND_TICK, 32'd2, 5'd0, 1'b0);
        send_item(KIND_TICK, 32'd1, 5'd0, 1'b0);
        send_item(KIND_TICK, 32'hFFFF_FFFF, 5'd0, 1'b0);
        send_item(KIND_TICK, 32'd6, 5'd0, 1'b0);
        send_item(KIND_TICK, 32'd100, 5'd0, 1'b0);
        send_item(KIND_SET_INDEX, 32'd0, 5'd31, 1'b1);
        send_item(KIND_SET_INDEX, 32'd0, 5'd0, 1'b0);
        send_item(KIND_TICK, 32'd0, 5'd0, 1'b0);
        send_item(KIND_SET_DONE, 32'd0, 5'd0, 1'b0);
        wait_idle();

        write_cfg(CFG_LOOP_MODE, 1'b1);
        send_item(KIND_TICK, 32'hFFFF_FFFF, 5'd0, 1'b0);
        send_item(KIND_TICK, 32'd13, 5'd0, 1'b0);
        send_item(KIND_SET_DONE, 32'd0, 5'd0, 1'b1);
        send_item(KIND_TICK, 32'd9, 5'd0, 1'b0);
        send_item(KIND_SET_DONE, 32'd0, 5'd0, 1'b0);
        wait_idle();

        write_cfg(CFG_PAUSE_FLAG, 1'b1);
        send_item(KIND_TICK, 32'd7, 5'd0, 1'b0);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_cfg(CFG_LOOP_MODE, loop_sel[p]);
            write_cfg(CFG_PAUSE_FLAG, pause_sel[p]);
            // one phase runs with no idling on either side
            gaps_on = (p != 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
            wait_idle();
        end
        gaps_on = 1'b1;

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/fds_pkg.sv
rtl/fds_in_if.sv
rtl/fds_out_if.sv
rtl/fds_ram.sv
rtl/fds_mod.sv
rtl/frame_duration_sequencer.sv
bench/frame_duration_sequencer_tb.sv
